[src/rls_pkg.sv]
package rls_pkg;

    // APB register port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    // register index, taken from the word address
    typedef enum logic
    {
        REG_ORIGIN_X = 1'b0,
        REG_ORIGIN_Y = 1'b1
    } reg_idx_t;

    // item kinds
    typedef enum logic
    {
        REQ_AIM   = 1'b0,
        REQ_FRAME = 1'b1
    } req_kind_t;

endpackage

[src/rls_if.sv]
interface rls_req_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;

    modport source (output valid, req_type, target_x, target_y, input ready);
    modport sink   (input valid, req_type, target_x, target_y, output ready);
endinterface

interface rls_res_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  arrived;

    modport source (output valid, point_x, point_y, arrived, input ready);
    modport sink   (input valid, point_x, point_y, arrived, output ready);
endinterface

[src/rls_cfg.sv]
module rls_cfg #(
    parameter int COORD_BITS = 10
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rls_pkg::PADDR_BITS-1:0] paddr,
    input  logic [rls_pkg::PDATA_BITS-1:0] pwdata,
    output logic [rls_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready,
    output logic [COORD_BITS-1:0]          origin_x,
    output logic [COORD_BITS-1:0]          origin_y
);

    logic [COORD_BITS-1:0] origin_x_reg;
    logic [COORD_BITS-1:0] origin_y_reg;
    logic [COORD_BITS-1:0] origin_x_next;
    logic [COORD_BITS-1:0] origin_y_next;
    rls_pkg::reg_idx_t     idx;
    logic                  wr_en;

    // word address: registers sit at byte offsets 0 and 4
    assign idx   = rls_pkg::reg_idx_t'(paddr[rls_pkg::PADDR_BITS-1]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        if (wr_en)
        begin
            case (idx)
                rls_pkg::REG_ORIGIN_X: origin_x_next = pwdata[COORD_BITS-1:0];
                rls_pkg::REG_ORIGIN_Y: origin_y_next = pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

    always_comb
    begin
        case (idx)
            rls_pkg::REG_ORIGIN_X: prdata = rls_pkg::PDATA_BITS'(origin_x_reg);
            rls_pkg::REG_ORIGIN_Y: prdata = rls_pkg::PDATA_BITS'(origin_y_reg);
            default:               prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign origin_x = origin_x_reg;
    assign origin_y = origin_y_reg;

endmodule

[src/rls_div.sv]
// Restoring divider, one quotient bit per cycle.
module rls_div #(
    parameter int W = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quot
);

    localparam int CNT_BITS = $clog2(W + 1);

    logic [W-1:0]        num_reg;
    logic [W-1:0]        num_next;
    logic [W-1:0]        den_reg;
    logic [W-1:0]        den_next;
    logic [W-1:0]        rem_reg;
    logic [W-1:0]        rem_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [W:0]          trial;
    logic [W:0]          diff;

    assign trial = {rem_reg, num_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where the dividend bits leave
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[W-1:0];
                num_next = {num_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                num_next = {num_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

[src/ratio_line_stepper_core.sv]
// Point stepper: moves a point from a programmable origin toward a target.
// Channels: req (sink) carries req_type, target_x, target_y; res (source)
// carries point_x, point_y, arrived. Each request item gives one result item.
// An aim item loads the target, puts the point at the origin and works out
// the step ratio: major / (minor + 1) rounded half up, redone as
// major / minor when that gives 1 and minor is not zero. A frame item
// moves the point one step. Registers origin_x (byte 0) and origin_y
// (byte 4) sit on the APB port. Flow: a frame item passes S_STEP and
// S_EMIT on its way to the output register. An aim with equal distances
// goes straight to S_EMIT; otherwise it runs one division on the shared
// restoring divider in S_DIV1 and, when that is redone, one more in S_DIV2.
// req.ready comes back the cycle after a result is loaded, so a new item
// is taken only after the last one has left S_EMIT.
// Only one item is in flight: req.ready is high only while idle. A finished
// result waits in the output register; the next item may be accepted and
// worked on meanwhile, but its result stays back until res is taken.
// Reset clears the origin, point, target and hit flag, ratio and frame
// counter to one, and leaves the block idle with no result pending.
module ratio_line_stepper_core #(
    parameter int COORD_BITS = 10
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    rls_req_if.sink                        req,
    rls_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rls_pkg::PADDR_BITS-1:0] paddr,
    input  logic [rls_pkg::PDATA_BITS-1:0] pwdata,
    output logic [rls_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 2;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_STEP,
        S_DIV1,
        S_DIV2,
        S_EMIT
    } state_t;

    typedef enum logic [1:0]
    {
        MODE_EQUAL,
        MODE_X_MAJOR,
        MODE_Y_MAJOR
    } mode_t;

    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    logic [CB-1:0]   pos_x_reg, pos_x_next;
    logic [CB-1:0]   pos_y_reg, pos_y_next;
    logic [CB-1:0]   goal_x_reg, goal_x_next;
    logic [CB-1:0]   goal_y_reg, goal_y_next;
    logic [CB-1:0]   ratio_reg, ratio_next;
    logic [CB-1:0]   frames_reg, frames_next;
    logic            hit_reg, hit_next;
    logic [CB-1:0]   maj_reg, maj_next;
    logic [CB-1:0]   mnr_reg, mnr_next;
    logic            out_valid_reg, out_valid_next;
    logic [CB-1:0]   out_x_reg, out_x_next;
    logic [CB-1:0]   out_y_reg, out_y_next;
    logic            out_hit_reg, out_hit_next;

    logic [CB-1:0]   origin_x;
    logic [CB-1:0]   origin_y;
    logic [CB-1:0]   dx;
    logic [CB-1:0]   dy;
    logic [CB-1:0]   aim_maj;
    logic [CB-1:0]   aim_mnr;
    logic [CB:0]     aim_den;
    logic            div_start;
    logic [DW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic            div_done;
    logic [DW-1:0]   div_quot;

    // frame stepping, major/minor view
    logic [CB-1:0]   mj;
    logic [CB-1:0]   gmj;
    logic [CB-1:0]   mn;
    logic [CB-1:0]   gmn;
    logic [CB-1:0]   fl;
    logic [CB-1:0]   new_x;
    logic [CB-1:0]   new_y;

    function automatic logic [CB-1:0] toward(input logic [CB-1:0] p, input logic [CB-1:0] g);
        logic [CB-1:0] r;
        r = p;
        if (p < g)
        begin
            r = p + CB'(1);
        end
        else if (p > g)
        begin
            r = p - CB'(1);
        end
        return r;
    endfunction

    rls_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .origin_x (origin_x),
        .origin_y (origin_y)
    );

    rls_div #(
        .W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign dx      = (req.target_x > origin_x) ? req.target_x - origin_x
                                               : origin_x - req.target_x;
    assign dy      = (req.target_y > origin_y) ? req.target_y - origin_y
                                               : origin_y - req.target_y;
    assign aim_maj = (dx > dy) ? dx : dy;
    assign aim_mnr = (dx > dy) ? dy : dx;
    assign aim_den = {1'b0, aim_mnr} + (CB + 1)'(1);

    // one frame along the major axis, or along both axes in equal mode
    always_comb
    begin
        if (mode_reg == MODE_Y_MAJOR)
        begin
            mj  = pos_y_reg;
            gmj = goal_y_reg;
            mn  = pos_x_reg;
            gmn = goal_x_reg;
        end
        else
        begin
            mj  = pos_x_reg;
            gmj = goal_x_reg;
            mn  = pos_y_reg;
            gmn = goal_y_reg;
        end
        fl = frames_reg - CB'(1);
        if (fl == '0)
        begin
            fl = ratio_reg;
            mn = toward(mn, gmn);
        end
        if (mj != gmj)
        begin
            mj = toward(mj, gmj);
        end
        else
        begin
            mn = gmn;
        end
        case (mode_reg)
            MODE_X_MAJOR:
            begin
                new_x = mj;
                new_y = mn;
            end
            MODE_Y_MAJOR:
            begin
                new_x = mn;
                new_y = mj;
            end
            default:
            begin
                new_x = toward(pos_x_reg, goal_x_reg);
                new_y = toward(pos_y_reg, goal_y_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        ratio_next     = ratio_reg;
        frames_next    = frames_reg;
        hit_next       = hit_reg;
        maj_next       = maj_reg;
        mnr_next       = mnr_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_hit_next   = out_hit_reg;
        div_start      = 1'b0;
        div_num        = {1'b0, aim_maj, 1'b0} + {1'b0, aim_den};
        div_den        = {aim_den, 1'b0};

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == rls_pkg::REQ_AIM)
                    begin
                        goal_x_next = req.target_x;
                        goal_y_next = req.target_y;
                        pos_x_next  = origin_x;
                        pos_y_next  = origin_y;
                        maj_next    = aim_maj;
                        mnr_next    = aim_mnr;
                        if (dx == dy)
                        begin
                            mode_next   = MODE_EQUAL;
                            ratio_next  = CB'(1);
                            frames_next = CB'(1);
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            mode_next  = (dx > dy) ? MODE_X_MAJOR : MODE_Y_MAJOR;
                            div_start  = 1'b1;
                            state_next = S_DIV1;
                        end
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                pos_x_next = new_x;
                pos_y_next = new_y;
                if (mode_reg == MODE_X_MAJOR || mode_reg == MODE_Y_MAJOR)
                begin
                    frames_next = fl;
                end
                hit_next   = (new_x == goal_x_reg) && (new_y == goal_y_reg);
                state_next = S_EMIT;
            end
            S_DIV1:
            begin
                div_num = {1'b0, maj_reg, 1'b0} + {2'b00, mnr_reg};
                div_den = {1'b0, mnr_reg, 1'b0};
                if (div_done)
                begin
                    // a ratio of one is redone against the bare minor distance, unless that is zero
                    if (div_quot == DW'(1) && mnr_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV2;
                    end
                    else
                    begin
                        ratio_next  = div_quot[CB-1:0];
                        frames_next = div_quot[CB-1:0];
                        state_next  = S_EMIT;
                    end
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    ratio_next  = div_quot[CB-1:0];
                    frames_next = div_quot[CB-1:0];
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = pos_x_reg;
                    out_y_next     = pos_y_reg;
                    out_hit_next   = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_EQUAL;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            ratio_reg     <= CB'(1);
            frames_reg    <= CB'(1);
            hit_reg       <= 1'b0;
            maj_reg       <= '0;
            mnr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            ratio_reg     <= ratio_next;
            frames_reg    <= frames_next;
            hit_reg       <= hit_next;
            maj_reg       <= maj_next;
            mnr_reg       <= mnr_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.point_x = out_x_reg;
    assign res.point_y = out_y_reg;
    assign res.arrived = out_hit_reg;

endmodule

[dv/ratio_line_stepper_core_tb.sv]
`timescale 1ns / 100ps

module ratio_line_stepper_core_tb;

    localparam int CB         = 10;
    localparam int WDOG_LIMIT = 3000;
    localparam int SETTLE     = 40;

    typedef enum logic [1:0]
    {
        AXIS_EQUAL   = 2'd0,
        AXIS_X_MAJOR = 2'd1,
        AXIS_Y_MAJOR = 2'd2
    } axis_t;

    typedef struct packed
    {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          hit;
    } point_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rls_pkg::PADDR_BITS-1:0] paddr;
    logic [rls_pkg::PDATA_BITS-1:0] pwdata;
    logic [rls_pkg::PDATA_BITS-1:0] prdata;
    logic                           pready;

    rls_req_if #(.COORD_BITS(CB)) req_ch ();
    rls_res_if #(.COORD_BITS(CB)) res_ch ();

    ratio_line_stepper_core #(.COORD_BITS(CB)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [CB-1:0] org_x, org_y;
    logic [CB-1:0] pos_x, pos_y;
    logic [CB-1:0] goal_x, goal_y;
    axis_t         axis;
    logic [CB-1:0] step_ratio;
    logic [CB-1:0] frames_left;
    logic          hit_flag;

    point_t expected_points[$];
    int     mismatches;
    bit     tx_idle;
    bit     rx_idle;
    int     hold_len;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [CB-1:0] toward(logic [CB-1:0] p, logic [CB-1:0] g);
        if (p < g)
            return p + 1'b1;
        else if (p > g)
            return p - 1'b1;
        else
            return p;
    endfunction

    function automatic int unsigned div_half_up(int unsigned n, int unsigned d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic logic [CB-1:0] ratio_of(int unsigned maj, int unsigned mnr);
        int unsigned r;
        r = div_half_up(maj, mnr + 1);
        // redo against the bare minor distance; no retry when minor is zero
        if (r == 1 && mnr != 0)
            r = div_half_up(maj, mnr);
        return r[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] near(logic [CB-1:0] c, int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > (1 << CB) - 1)
            v = (1 << CB) - 1;
        return v[CB-1:0];
    endfunction

    task automatic reset_model();
        org_x       = '0;
        org_y       = '0;
        pos_x       = '0;
        pos_y       = '0;
        goal_x      = '0;
        goal_y      = '0;
        axis        = AXIS_EQUAL;
        step_ratio  = CB'(1);
        frames_left = CB'(1);
        hit_flag    = 1'b0;
    endtask

    task automatic predict_point(input rls_pkg::req_kind_t kind, input logic [CB-1:0] tx,
                                 input logic [CB-1:0] ty, output point_t p);
        int unsigned   dx, dy;
        logic [CB-1:0] mj, mn, gmj, gmn;
        if (kind == rls_pkg::REQ_AIM)
        begin
            goal_x = tx;
            goal_y = ty;
            pos_x  = org_x;
            pos_y  = org_y;
            dx = 32'((goal_x > org_x) ? goal_x - org_x : org_x - goal_x);
            dy = 32'((goal_y > org_y) ? goal_y - org_y : org_y - goal_y);
            if (dx > dy)
            begin
                axis       = AXIS_X_MAJOR;
                step_ratio = ratio_of(dx, dy);
            end
            else if (dx == dy)
            begin
                axis       = AXIS_EQUAL;
                step_ratio = CB'(1);
            end
            else
            begin
                axis       = AXIS_Y_MAJOR;
                step_ratio = ratio_of(dy, dx);
            end
            frames_left = step_ratio;
        end
        else
        begin
            if (axis == AXIS_EQUAL)
            begin
                pos_y = toward(pos_y, goal_y);
                pos_x = toward(pos_x, goal_x);
            end
            else
            begin
                if (axis == AXIS_X_MAJOR)
                begin
                    mj = pos_x; gmj = goal_x; mn = pos_y; gmn = goal_y;
                end
                else
                begin
                    mj = pos_y; gmj = goal_y; mn = pos_x; gmn = goal_x;
                end
                frames_left = frames_left - 1'b1;
                if (frames_left == 0)
                begin
                    frames_left = step_ratio;
                    mn = toward(mn, gmn);
                end
                // minor snaps once the major axis is home
                if (mj != gmj)
                    mj = toward(mj, gmj);
                else
                    mn = gmn;
                if (axis == AXIS_X_MAJOR)
                begin
                    pos_x = mj; pos_y = mn;
                end
                else
                begin
                    pos_y = mj; pos_x = mn;
                end
            end
            hit_flag = (pos_x == goal_x) && (pos_y == goal_y);
        end
        p.px  = pos_x;
        p.py  = pos_y;
        p.hit = hit_flag;
    endtask

    task automatic send_item(input rls_pkg::req_kind_t kind, input logic [CB-1:0] tx,
                             input logic [CB-1:0] ty);
        int     g;
        point_t want;
        g = tx_idle ? idle_gap() : 0;
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.target_x <= tx;
        req_ch.target_y <= ty;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_point(kind, tx, ty, want);
        expected_points.push_back(want);
    endtask

    task automatic send_frames(input int n);
        repeat (n) send_item(rls_pkg::REQ_FRAME, CB'($urandom), CB'($urandom));
    endtask

    // idle the request side and let every pending item come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input rls_pkg::reg_idx_t idx, input logic [CB-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rls_pkg::PADDR_BITS'(int'(idx) * 4);
        // upper bits are junk; the block keeps only CB bits
        pwdata  <= {$urandom} & ~rls_pkg::PDATA_BITS'((1 << CB) - 1)
                   | rls_pkg::PDATA_BITS'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rls_pkg::REG_ORIGIN_X)
            org_x = v;
        else
            org_y = v;
    endtask

    task automatic aim_walk(input logic [CB-1:0] tx, input logic [CB-1:0] ty,
                            input int n);
        send_item(rls_pkg::REQ_AIM, tx, ty);
        send_frames(n);
    endtask

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_frames(2);                 // frames on the reset state
        aim_walk(0, 0, 1);              // zero distance
        aim_walk(1, 0, 2);              // divide-by-zero guard
        aim_walk(2, 1, 3);              // ratio of one, redone
        aim_walk(1023, 0, 2);
        aim_walk(0, 1023, 1);
        aim_walk(1023, 1023, 2);        // diagonal
        aim_walk(3, 7, 4);
    endtask

    task automatic test_origin_extremes();
        drain();
        cfg_write(rls_pkg::REG_ORIGIN_X, '1);
        cfg_write(rls_pkg::REG_ORIGIN_Y, '1);
        aim_walk(0, 0, 3);
        aim_walk(1023, 1023, 1);
        aim_walk(1022, 1023, 2);
        drain();
        cfg_write(rls_pkg::REG_ORIGIN_X, '0);
        aim_walk(1023, 0, 2);
        aim_walk(1020, 1023, 5);
    endtask

    task automatic test_random_lines();
        int   count, r, span, reach, nf, dx, dy;
        logic [CB-1:0] tx, ty;
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    cfg_write(rls_pkg::REG_ORIGIN_X, '0);
                    cfg_write(rls_pkg::REG_ORIGIN_Y, '0);
                end
                1:
                begin
                    cfg_write(rls_pkg::REG_ORIGIN_X, '1);
                    cfg_write(rls_pkg::REG_ORIGIN_Y, '1);
                end
                2:
                begin
                    cfg_write(rls_pkg::REG_ORIGIN_X, '1);
                    cfg_write(rls_pkg::REG_ORIGIN_Y, '0);
                end
                3:
                begin
                    cfg_write(rls_pkg::REG_ORIGIN_X, '0);
                    cfg_write(rls_pkg::REG_ORIGIN_Y, '1);
                end
                default:
                begin
                    cfg_write(rls_pkg::REG_ORIGIN_X, CB'($urandom));
                    cfg_write(rls_pkg::REG_ORIGIN_Y, CB'($urandom));
                end
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            count = 0;
            while (count < 290)
            begin
                r = $urandom_range(0, 99);
                if (r < 88)
                begin
                    r = $urandom_range(0, 9);
                    span = (r < 4) ? 4 : (r < 7) ? 20 : (r < 9) ? 100 : 1023;
                    tx = near(org_x, span);
                    ty = near(org_y, span);
                    dx = 32'((tx > org_x) ? tx - org_x : org_x - tx);
                    dy = 32'((ty > org_y) ? ty - org_y : org_y - ty);
                    reach = (dx > dy) ? dx : dy;
                    nf = (reach <= 150) ? reach + $urandom_range(0, 4) : $urandom_range(1, 40);
                    aim_walk(tx, ty, nf);
                    count += nf + 1;
                end
                else if (r < 94)
                begin
                    send_item(rls_pkg::REQ_AIM, CB'($urandom), CB'($urandom));
                    count++;
                end
                else
                begin
                    nf = $urandom_range(1, 6);
                    send_frames(nf);
                    count += nf;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        drain();
        tx_idle  = 1'b0;
        hold_len = 400;
        aim_walk(near(org_x, 6), near(org_y, 6), 12);
        aim_walk(near(org_x, 30), near(org_y, 30), 17);
        rx_idle = 1'b1;
        tx_idle = 1'b1;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int g;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                g = hold_len;
                hold_len = 0;
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            else
            begin
                g = rx_idle ? idle_gap() : 0;
                if (g > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : check_results
        point_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: point %0d,%0d arrived %0b",
                                 res_ch.point_x, res_ch.point_y, res_ch.arrived);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (res_ch.point_x !== want.px || res_ch.point_y !== want.py ||
                        res_ch.arrived !== want.hit)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d,%0d,%0b got %0d,%0d,%0b",
                                     want.px, want.py, want.hit,
                                     res_ch.point_x, res_ch.point_y, res_ch.arrived);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                    quiet = 0;
                else
                    quiet++;
                if (quiet >= WDOG_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= rls_pkg::REQ_AIM;
        req_ch.target_x <= '0;
        req_ch.target_y <= '0;
        mismatches = 0;
        hold_len   = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_origin_extremes();
        test_random_lines();
        test_backpressure();

        drain();
        if (mismatches == 0 && expected_points.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[ratio_line_stepper_core.f]
src/rls_pkg.sv
src/rls_if.sv
src/rls_cfg.sv
src/rls_div.sv
src/ratio_line_stepper_core.sv
dv/ratio_line_stepper_core_tb.sv
